### rtl/maf_pkg.sv
// Shared types and fixed constants of the moving average filter.
package maf_pkg;

	localparam int WL_WIDTH = 7;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} div_status_t;

endpackage

### rtl/moving_average_filter_unit.sv
// Top level of the moving average filter: sample chain, running sum and output stage.
//
// Usage:
//   Slave stream s_*: s_tdata carries one signed sample, s_tuser the restart flag,
//   which empties the window before that sample is taken.
//   Master stream m_*: m_tdata carries the signed mean of the held samples,
//   truncated toward zero; one result transaction per input transaction.
//   cfg_wen/cfg_wdata write the window length (0 reads as 1, values above
//   MAX_WINDOW read as MAX_WINDOW); a write empties the window.
// Timing:
//   A sample shifts into the cell chain and updates the running sum on the
//   accepting edge; the mean then comes from a bit-serial divider, one quotient
//   bit per cycle over SAMPLE_WIDTH + clog2(MAX_WINDOW) bits (38 by default).
//   m_tvalid rises once the result has moved from the divider into the output register;
//   a new sample is taken only after the divider's result has gone to that register.
// Reset: window empty, length 1, no result pending.
// Stall: the result waits in the output register while the divider may finish
//   the next one; s_tready stays low while the divider holds a result.
module moving_average_filter_unit #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,   // [0+:SAMPLE_WIDTH] sample
	input  logic                                      s_tuser,   // [0] restart
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,   // [0+:SAMPLE_WIDTH] average
	input  logic                                      cfg_wen,
	input  logic [maf_pkg::WL_WIDTH-1:0]              cfg_wdata
);

	import maf_pkg::*;

	localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int SW = SAMPLE_WIDTH;
	localparam int TW = SW + $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [WL_WIDTH-1:0] wl_q;
	logic [CW-1:0]       fill_q;
	logic signed [TW-1:0] total_q;
	logic                m_tvalid_q;
	logic [SW-1:0]       m_data_q;

	logic [SW-1:0]        cell_q [MAX_WINDOW];
	logic [CW-1:0]        w;
	logic [CW-1:0]        wm1;
	logic                 accept;
	logic signed [SW-1:0] sample_s;
	logic signed [SW-1:0] oldest;
	logic [CW-1:0]        fill_eff;
	logic signed [TW-1:0] total_eff;
	logic                 full;
	logic signed [TW-1:0] sub_v;
	logic signed [TW-1:0] new_total;
	logic [CW-1:0]        new_fill;
	logic                 load;
	div_status_t          div_st;
	logic [SW-1:0]        div_res;

	always_comb begin
		if (wl_q == '0) begin
			w = CW'(1);
		end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
			w = CW'(MAX_WINDOW);
		end else begin
			w = CW'(wl_q);
		end
	end

	assign wm1       = w - 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !div_st.busy && !div_st.res_valid;
	assign sample_s  = s_tdata[SW-1:0];
	assign oldest    = cell_q[wm1[IW-1:0]];
	assign fill_eff  = s_tuser ? '0 : fill_q;
	assign total_eff = s_tuser ? '0 : total_q;
	assign full      = fill_eff >= w;
	assign sub_v     = full ? TW'(oldest) : '0;
	assign new_total = total_eff - sub_v + TW'(sample_s);
	assign new_fill  = full ? w : fill_eff + 1'b1;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			maf_cell #(.WIDTH(SW)) u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (s_tdata[SW-1:0]),
				.q     (cell_q[i])
			);
		end else begin : g_body
			maf_cell #(.WIDTH(SW)) u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (cell_q[i-1]),
				.q     (cell_q[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= WL_WIDTH'(1);
			fill_q  <= '0;
			total_q <= '0;
		end else if (cfg_wen) begin
			wl_q    <= cfg_wdata;
			fill_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			fill_q  <= new_fill;
			total_q <= new_total;
		end
	end

	maf_divider #(
		.NUM_WIDTH (TW),
		.DEN_WIDTH (CW),
		.RES_WIDTH (SW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (new_total),
		.divisor  (new_fill),
		.ack      (load),
		.status   (div_st),
		.quotient (div_res)
	);

	assign load = div_st.res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= div_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'(m_data_q);

`ifndef ASSERT_OFF
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w) else $error("fill count beyond window length");
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (total_q == '0)) else $error("empty window with nonzero sum");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> div_st.busy) else $error("divider not started on transaction");
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(div_st.res_valid && !m_tvalid_q) |=> m_tvalid_q) else $error("result not moved out");
`endif

endmodule

### rtl/maf_cell.sv
// One cell of the sample shift chain: holds one sample, takes the one on d (its neighbour's) on a shift.
module maf_cell #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             shift,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

### rtl/maf_divider.sv
// Bit-serial signed divider: signed sum over unsigned count, truncated toward zero.
module maf_divider #(
	parameter int NUM_WIDTH = 38,
	parameter int DEN_WIDTH = 7,
	parameter int RES_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [NUM_WIDTH-1:0] dividend,
	input  logic        [DEN_WIDTH-1:0] divisor,
	input  logic                        ack,
	output maf_pkg::div_status_t        status,
	output logic        [RES_WIDTH-1:0] quotient
);

	import maf_pkg::*;

	localparam int CNT_W = $clog2(NUM_WIDTH + 1);

	logic                 busy_q;
	logic                 valid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [NUM_WIDTH-1:0] quo_q;
	logic [DEN_WIDTH-1:0] rem_q;
	logic [DEN_WIDTH-1:0] den_q;

	logic [NUM_WIDTH-1:0] raw;
	logic [NUM_WIDTH-1:0] abs_in;
	logic [DEN_WIDTH:0]   trial;
	logic [DEN_WIDTH:0]   diff;
	logic                 ge;
	logic [RES_WIDTH-1:0] mag;

	assign raw    = dividend;
	assign abs_in = raw[NUM_WIDTH-1] ? (~raw + 1'b1) : raw;
	assign trial  = {rem_q, quo_q[NUM_WIDTH-1]};
	assign ge     = trial >= {1'b0, den_q};
	assign diff   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q  <= 1'b0;
					valid_q <= 1'b1;
				end
			end
			if (ack) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= raw[NUM_WIDTH-1];
			quo_q <= abs_in;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
		end
	end

	assign mag              = quo_q[RES_WIDTH-1:0];
	assign quotient         = neg_q ? (~mag + 1'b1) : mag;
	assign status.busy      = busy_q;
	assign status.res_valid = valid_q;

endmodule

### sim/tb_moving_average_filter_unit.sv
// Self-checking testbench of the moving average filter unit.
`timescale 1ns / 1ps

module tb_moving_average_filter_unit;

	import maf_pkg::*;

	localparam int MAX_WIN      = 64;
	localparam int SMP_W        = 32;
	localparam int DW           = ((SMP_W + 7) / 8) * 8;
	localparam int LIMIT_CYCLES = 300000;
	localparam int TAIL_CYCLES  = 45;
	localparam int RING_DEPTH   = 256;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [DW-1:0]      s_tdata   = '0;
	logic               s_tuser   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [DW-1:0]      m_tdata;
	logic               cfg_wen   = 1'b0;
	logic [WL_WIDTH-1:0] cfg_wdata = '0;

	// predictor state
	logic signed [SMP_W-1:0] held_samples [MAX_WIN];
	int unsigned             next_slot;
	int unsigned             held_count;
	longint                  window_sum;
	logic [WL_WIDTH-1:0]     window_reg;

	// expected averages in order of their transactions
	logic [SMP_W-1:0] mean_ring [RING_DEPTH];
	int               ring_wr = 0;
	int               ring_rd = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;
	int hold_trigger   = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int errors         = 0;
	int samples_sent   = 0;
	int means_checked  = 0;
	int restarts_sent  = 0;
	int window_writes  = 0;

	moving_average_filter_unit #(
		.MAX_WINDOW  (MAX_WIN),
		.SAMPLE_WIDTH(SMP_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] sample
		.s_tuser  (s_tuser),   // [0] restart
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] average
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pending_count();
		return ring_wr - ring_rd;
	endfunction

	function automatic void clear_window();
		next_slot  = 0;
		held_count = 0;
		window_sum = 0;
	endfunction

	function automatic logic [SMP_W-1:0] predict_mean(logic signed [SMP_W-1:0] smp, logic rst);
		int unsigned span;
		int unsigned oldest;
		longint      mean;
		span = (window_reg < 1) ? 1 : ((window_reg > MAX_WIN) ? MAX_WIN : window_reg);
		if (rst) begin
			clear_window();
		end
		if (held_count >= span) begin
			oldest = (next_slot + MAX_WIN - span) % MAX_WIN;
			window_sum -= held_samples[oldest];
			held_count = span;
		end else begin
			held_count++;
		end
		held_samples[next_slot] = smp;
		window_sum += smp;
		next_slot = (next_slot + 1) % MAX_WIN;
		mean = window_sum / longint'(held_count);
		return mean[SMP_W-1:0];
	endfunction

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(5))
			0: return $urandom_range(2) == 0 ? 32'h7FFF_FFFF :
				($urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFF);
			1: return 32'($signed($urandom_range(2000)) - 1000);
			2: return 32'h7FFF_0000 | 32'($urandom_range(16'hFFFF));
			3: return 32'h8000_0000 | 32'($urandom_range(16'hFFFF));
			default: return $urandom;
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic push_sample(input logic [SMP_W-1:0] smp, input logic rst);
		if (send_idle_pct != 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= rst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mean_ring[ring_wr % RING_DEPTH] = predict_mean(smp, rst);
		ring_wr++;
		samples_sent++;
		if (rst) restarts_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_count() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_window(input logic [WL_WIDTH-1:0] len);
		cfg_wen   <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_wen <= 1'b0;
		window_reg = len;
		clear_window();
		window_writes++;
		@(negedge clk);
	endtask

	task automatic test_directed();
		push_sample(32'h7FFF_FFFF, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h0000_0000, 1'b0);
		push_sample(32'hFFFF_FFFF, 1'b0);
		wait_drained();
		// zero length reads as one
		write_window(7'd0);
		push_sample(32'h0000_0001, 1'b0);
		push_sample(32'hFFFF_FFFF, 1'b0);
		wait_drained();
		// negative sums truncate toward zero
		write_window(7'd2);
		push_sample(32'hFFFF_FFFF, 1'b0);
		push_sample(32'hFFFF_FFFE, 1'b0);
		push_sample(32'h0000_0003, 1'b0);
		push_sample(32'h0000_0005, 1'b1);
		wait_drained();
		// above the maximum clamps
		write_window(7'd127);
		repeat (3) push_sample(32'h7FFF_FFFF, 1'b0);
		repeat (3) push_sample(32'h8000_0000, 1'b0);
		wait_drained();
		write_window(7'd65);
		push_sample(32'h8000_0000, 1'b1);
		push_sample(32'h8000_0000, 1'b0);
		wait_drained();
		write_window(7'd3);
		push_sample(32'h0000_0001, 1'b0);
		push_sample(32'h0000_0002, 1'b0);
		push_sample(32'h0000_0002, 1'b0);
		push_sample(32'hFFFF_FFF9, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(input int snd_pct, input int rcv_pct,
			input logic [WL_WIDTH-1:0] len, input int n_items);
		wait_drained();
		write_window(len);
		send_idle_pct  = snd_pct;
		recv_stall_pct = rcv_pct;
		repeat (n_items) push_sample(rand_sample(), $urandom_range(47) == 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		wait_drained();
		write_window(7'd8);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len       = 400;
		hold_trigger++;
		repeat (12) push_sample(rand_sample(), 1'b0);
		// sender pauses until the pipeline has emptied
		wait_drained();
		repeat (10) push_sample(rand_sample(), $urandom_range(3) == 0);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_count() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, m_tdata[SMP_W-1:0]);
				errors++;
			end else begin
				if (m_tdata[SMP_W-1:0] !== mean_ring[ring_rd % RING_DEPTH]) begin
					$display("%0t: average mismatch, expected %h, actual %h",
						$time, mean_ring[ring_rd % RING_DEPTH], m_tdata[SMP_W-1:0]);
					errors++;
				end
				ring_rd++;
				means_checked++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("tb_moving_average_filter_unit: done, errors");
		$finish;
	end

	initial begin : main
		window_reg = 7'd1;
		clear_window();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(0, 0, 7'd64, 140);
		test_random_phase(76, 0, 7'd5, 130);
		test_random_phase(0, 76, 7'd127, 130);
		test_random_phase(11, 11, 7'($urandom_range(127)), 130);
		test_random_phase(0, 0, 7'($urandom_range(1, 12)), 100);
		test_backpressure();

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_count() != 0) begin
			$display("%0t: %0d expected averages never arrived", $time, pending_count());
			errors++;
		end
		$display("Sent %0d samples (%0d with restart) over %0d window length writes,",
			samples_sent, restarts_sent, window_writes);
		$display("checked %0d averages under idle, stall and hold-off phases, %0d errors.",
			means_checked, errors);
		if (errors == 0) begin
			$display("tb_moving_average_filter_unit: done, clean");
		end else begin
			$display("tb_moving_average_filter_unit: done, errors");
		end
		$finish;
	end

endmodule

### moving_average_filter_unit.f
rtl/maf_pkg.sv
rtl/maf_cell.sv
rtl/maf_divider.sv
rtl/moving_average_filter_unit.sv
sim/tb_moving_average_filter_unit.sv
